// ===== sv/gdr_pkg.sv =====
// ----------------------------------------------------------------------------
// gdr_pkg: shared types, constants and helpers of the grid DDA ray caster
// Holds the map and angle sizing, the item and result records, the
// configuration record and the divider request/response records.
// ----------------------------------------------------------------------------
package gdr_pkg;

    // map and angle sizing
    localparam int MAP_SIZE   = 16;
    localparam int ANGLE_BITS = 12;
    localparam int MAP_IDX_W  = $clog2(MAP_SIZE);
    localparam int CELL_W     = MAP_IDX_W + 2;
    localparam int WALK_STEPS = 2 * MAP_SIZE + 2;
    localparam int WALK_CNT_W = $clog2(WALK_STEPS + 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    // sine polynomial coefficients, Q14
    localparam logic [15:0] ONE_Q14 = 16'd16384;
    localparam logic [15:0] SIN_A   = 16'd25736;
    localparam logic [15:0] SIN_B   = 16'd10512;
    localparam logic [15:0] SIN_C   = 16'd1160;
    localparam logic [23:0] MAX24   = 24'hFFFFFF;

    // datapath widths
    localparam int DIST_W  = 37;
    localparam int MUL_A_W = DIST_W;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 32;
    localparam int DIV_D_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // queue depth between front and back
    localparam int QDEPTH = 2;

    // item modes
    localparam logic MODE_WRITE_ROW = 1'b0;
    localparam logic MODE_CAST      = 1'b1;

    // register indexes (address bits [3:2])
    localparam logic [1:0] REG_FOV   = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_CELL  = 2'd2;

    localparam logic [11:0] FOV_RESET   = 12'd1024;
    localparam logic [10:0] WIDTH_RESET = 11'd800;
    localparam logic [7:0]  CELL_RESET  = 8'd32;

    typedef struct packed {
        logic        mode;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic [9:0]  column;
        logic [23:0] origin_x;
        logic [23:0] origin_y;
        logic [11:0] view_angle;
    } item_t;

    typedef struct packed {
        logic [23:0] hit_x;
        logic [23:0] hit_y;
        logic [23:0] distance;
        logic        hit_side;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic        out_of_map;
    } result_t;

    typedef struct packed {
        logic [11:0] field_of_view;
        logic [10:0] screen_width;
        logic [7:0]  cell_size;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quo;
        logic [DIV_D_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic [15:0] t;
        logic        neg;
    } sine_arg_t;

    // fold an angle into a quarter-wave argument and a sign
    function automatic sine_arg_t sine_arg(input logic [ANGLE_BITS-1:0] a);
        sine_arg_t   r;
        logic [1:0]  q;
        logic [15:0] t0;
        q  = a[ANGLE_BITS-1:ANGLE_BITS-2];
        t0 = 16'(32'(a[ANGLE_BITS-3:0]) << (16 - ANGLE_BITS));
        r.t   = q[0] ? (ONE_Q14 - t0) : t0;
        r.neg = q[1];
        return r;
    endfunction

endpackage

// ===== sv/gdr_front.sv =====
// ----------------------------------------------------------------------------
// gdr_front: input side of the ray caster
// Accepts stream transactions, unpacks them into item records and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module gdr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [95:0]     s_tdata,   // row_index, row_bits, column, origin_x,
                                       // origin_y, view_angle, zero fill
    input  logic            s_tuser,   // mode
    output logic            q_valid,
    output gdr_pkg::item_t  q_item,
    input  logic            q_pop
);

    gdr_pkg::item_t entry_reg [gdr_pkg::QDEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    gdr_pkg::item_t in_item;
    logic           push;

    // unpack the incoming transaction
    always_comb
    begin
        in_item.mode       = s_tuser;
        in_item.row_index  = s_tdata[3:0];
        in_item.row_bits   = s_tdata[19:4];
        in_item.column     = s_tdata[29:20];
        in_item.origin_x   = s_tdata[53:30];
        in_item.origin_y   = s_tdata[77:54];
        in_item.view_angle = s_tdata[89:78];
    end

    assign s_tready = (count_reg != 2'(gdr_pkg::QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(gdr_pkg::QDEPTH))
        else $error("queue fill count beyond depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ===== sv/gdr_div.sv =====
// ----------------------------------------------------------------------------
// gdr_div: iterative restoring divider
// One quotient bit per cycle; raises done once all DIV_N_W quotient bits
// are in, with quotient and remainder ready.
// ----------------------------------------------------------------------------
module gdr_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  gdr_pkg::div_req_t req,
    output gdr_pkg::div_rsp_t rsp
);

    logic [gdr_pkg::DIV_N_W-1:0]   num_reg;
    logic [gdr_pkg::DIV_D_W-1:0]   den_reg;
    logic [gdr_pkg::DIV_D_W-1:0]   rem_reg;
    logic [gdr_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [gdr_pkg::DIV_D_W:0]     trial;
    logic                          fits;

    // trial subtract of the next dividend bit
    always_comb
    begin
        trial = {rem_reg, num_reg[gdr_pkg::DIV_N_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == gdr_pkg::DIV_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= gdr_pkg::DIV_CNT_W'(gdr_pkg::DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == gdr_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // shift quotient bits in, keep partial remainder
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[gdr_pkg::DIV_N_W-2:0], fits};
            rem_reg <= fits ? gdr_pkg::DIV_D_W'(trial - {1'b0, den_reg})
                            : trial[gdr_pkg::DIV_D_W-1:0];
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;
    assign rsp.rem  = rem_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

// ===== sv/gdr_back.sv =====
// ----------------------------------------------------------------------------
// gdr_back: execution side of the ray caster
// Writes map rows, and for a ray: derives the angle, the direction from the
// sine polynomial, the cell and side distances through the shared divider,
// walks the grid one cell per cycle and forms the end point.
// ----------------------------------------------------------------------------
module gdr_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  gdr_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  gdr_pkg::item_t    q_item,
    output logic              q_pop,
    output gdr_pkg::div_req_t div_req,
    input  gdr_pkg::div_rsp_t div_rsp,
    output logic              m_tvalid,
    input  logic              m_tready,
    output gdr_pkg::result_t  m_result
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_AMUL   = 4'd1;
    localparam logic [3:0] ST_DSTART = 4'd2;
    localparam logic [3:0] ST_DWAIT  = 4'd3;
    localparam logic [3:0] ST_SQ     = 4'd4;
    localparam logic [3:0] ST_SC     = 4'd5;
    localparam logic [3:0] ST_SI     = 4'd6;
    localparam logic [3:0] ST_SO     = 4'd7;
    localparam logic [3:0] ST_SR     = 4'd8;
    localparam logic [3:0] ST_WALK   = 4'd9;
    localparam logic [3:0] ST_EX     = 4'd10;
    localparam logic [3:0] ST_EY     = 4'd11;
    localparam logic [3:0] ST_EF     = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;

    localparam logic [2:0] J_ANG = 3'd0;
    localparam logic [2:0] J_MX  = 3'd1;
    localparam logic [2:0] J_MY  = 3'd2;
    localparam logic [2:0] J_DDX = 3'd3;
    localparam logic [2:0] J_SX  = 3'd4;
    localparam logic [2:0] J_DDY = 3'd5;
    localparam logic [2:0] J_SY  = 3'd6;

    localparam int DW = gdr_pkg::DIST_W;
    localparam int CW = gdr_pkg::CELL_W;
    localparam int IW = gdr_pkg::MAP_IDX_W;
    localparam int AB = gdr_pkg::ANGLE_BITS;

    // end point: origin moved by the truncated offset, clamped to 24 bits
    function automatic logic [23:0] end_coord(input logic [23:0] o,
                                              input logic [gdr_pkg::MUL_P_W-15:0] off,
                                              input logic neg);
        logic [gdr_pkg::MUL_P_W-14:0] v;
        if (neg)
        begin
            v = (off > (gdr_pkg::MUL_P_W-14)'(o)) ? '0
                : (gdr_pkg::MUL_P_W-13)'(o) - (gdr_pkg::MUL_P_W-13)'(off);
        end
        else
        begin
            v = (gdr_pkg::MUL_P_W-13)'(o) + (gdr_pkg::MUL_P_W-13)'(off);
        end
        return (v > (gdr_pkg::MUL_P_W-13)'(gdr_pkg::MAX24)) ? gdr_pkg::MAX24 : v[23:0];
    endfunction

    logic [3:0]                  state_reg, state_next;
    logic [2:0]                  job_reg, job_next;

    logic [gdr_pkg::MAP_SIZE-1:0] wall_map_reg [gdr_pkg::MAP_SIZE];
    gdr_pkg::item_t              item_reg;
    logic [gdr_pkg::MUL_A_W-1:0] mul_a;
    logic [gdr_pkg::MUL_B_W-1:0] mul_b;
    logic [gdr_pkg::MUL_P_W-1:0] prod_reg;
    logic [AB-1:0]               ang_reg;
    logic [15:0]                 t_reg;
    logic                        sneg_reg;
    logic                        which_reg;
    logic [15:0]                 x2_reg;
    logic [15:0]                 magx_reg, magy_reg;
    logic                        negx_reg, negy_reg;
    logic [gdr_pkg::DIV_D_W-1:0] remx_reg, remy_reg;
    logic                        inmap_x_reg, inmap_y_reg;
    logic [CW-1:0]               cx_reg, cy_reg;
    logic [DW-1:0]               sx_reg, sy_reg, ddx_reg, ddy_reg, dist_reg;
    logic                        side_reg, outmap_reg;
    logic [gdr_pkg::WALK_CNT_W-1:0] walk_cnt_reg;
    logic [23:0]                 hitx_reg;
    logic [23:0]                 hity_reg;
    logic                        out_valid_reg;
    gdr_pkg::result_t            out_reg;

    logic [15:0]                 cellq;
    logic [15:0]                 sw_eff;
    logic [31:0]                 ang_full;
    logic [AB-1:0]               ang_new;
    gdr_pkg::sine_arg_t          arg_x, arg_y;
    logic [15:0]                 edge_x, edge_y;
    logic                        movex, movey, pick_y;
    logic [CW-1:0]               ncx, ncy;
    logic                        n_out, n_wall;
    logic                        out_free;
    logic [gdr_pkg::MAP_SIZE+15:0] row_ext;

    // effective configuration
    assign cellq  = {(cfg.cell_size == 8'd0) ? 8'd1 : cfg.cell_size, 8'd0};
    assign sw_eff = (cfg.screen_width == 11'd0) ? 16'd1 : 16'(cfg.screen_width);
    assign movex  = (magx_reg != 16'd0);
    assign movey  = (magy_reg != 16'd0);
    assign edge_x = negx_reg ? remx_reg : cellq - remx_reg;
    assign edge_y = negy_reg ? remy_reg : cellq - remy_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign row_ext  = {{gdr_pkg::MAP_SIZE{1'b0}}, q_item.row_bits};

    // ray angle from the angle divide quotient
    assign ang_full = 32'(item_reg.view_angle) + 32'(cfg.field_of_view >> 1) - div_rsp.quo;
    assign ang_new  = ang_full[AB-1:0];
    assign arg_x    = gdr_pkg::sine_arg(ang_new + gdr_pkg::QUARTER);
    assign arg_y    = gdr_pkg::sine_arg(ang_reg);

    // one DDA step: pick an axis, move, test bounds and wall
    always_comb
    begin
        pick_y = movey && (!movex || (sy_reg < sx_reg));
        ncx = cx_reg;
        ncy = cy_reg;
        if (pick_y)
        begin
            ncy = negy_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
        end
        else
        begin
            ncx = negx_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
        end
        n_out = ncx[CW-1] || (ncx[CW-2:0] >= (CW-1)'(gdr_pkg::MAP_SIZE))
             || ncy[CW-1] || (ncy[CW-2:0] >= (CW-1)'(gdr_pkg::MAP_SIZE));
        n_wall = !n_out && wall_map_reg[ncy[IW-1:0]][ncx[IW-1:0]];
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_AMUL:
            begin
                mul_a = gdr_pkg::MUL_A_W'(item_reg.column);
                mul_b = gdr_pkg::MUL_B_W'(cfg.field_of_view);
            end
            ST_SQ:
            begin
                mul_a = gdr_pkg::MUL_A_W'(t_reg);
                mul_b = t_reg;
            end
            ST_SC:
            begin
                mul_a = gdr_pkg::MUL_A_W'(prod_reg[29:14]);
                mul_b = gdr_pkg::SIN_C;
            end
            ST_SI:
            begin
                mul_a = gdr_pkg::MUL_A_W'(x2_reg);
                mul_b = gdr_pkg::SIN_B - prod_reg[29:14];
            end
            ST_SO:
            begin
                mul_a = gdr_pkg::MUL_A_W'(t_reg);
                mul_b = gdr_pkg::SIN_A - prod_reg[29:14];
            end
            ST_EX:
            begin
                mul_a = dist_reg;
                mul_b = magx_reg;
            end
            ST_EY:
            begin
                mul_a = dist_reg;
                mul_b = magy_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider request
    always_comb
    begin
        div_req.start = (state_reg == ST_DSTART);
        div_req.num   = '0;
        div_req.den   = 16'd1;
        case (job_reg)
            J_ANG:
            begin
                div_req.num = prod_reg[31:0];
                div_req.den = sw_eff;
            end
            J_MX:
            begin
                div_req.num = 32'(item_reg.origin_x);
                div_req.den = cellq;
            end
            J_MY:
            begin
                div_req.num = 32'(item_reg.origin_y);
                div_req.den = cellq;
            end
            J_DDX:
            begin
                div_req.num = 32'(cellq) << 14;
                div_req.den = magx_reg;
            end
            J_SX:
            begin
                div_req.num = 32'(edge_x) << 14;
                div_req.den = magx_reg;
            end
            J_DDY:
            begin
                div_req.num = 32'(cellq) << 14;
                div_req.den = magy_reg;
            end
            J_SY:
            begin
                div_req.num = 32'(edge_y) << 14;
                div_req.den = magy_reg;
            end
            default:
            begin
                div_req.num = '0;
                div_req.den = 16'd1;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.mode == gdr_pkg::MODE_CAST)
                    begin
                        state_next = ST_AMUL;
                    end
                end
            end
            ST_AMUL:
            begin
                job_next   = J_ANG;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = ST_DWAIT;
            end
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DSTART;
                    case (job_reg)
                        J_ANG: state_next = ST_SQ;
                        J_MX:  job_next = J_MY;
                        J_MY:
                        begin
                            if (movex)
                            begin
                                job_next = J_DDX;
                            end
                            else if (movey)
                            begin
                                job_next = J_DDY;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        J_DDX: job_next = J_SX;
                        J_SX:
                        begin
                            if (movey)
                            begin
                                job_next = J_DDY;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        J_DDY: job_next = J_SY;
                        default: state_next = ST_WALK;
                    endcase
                end
            end
            ST_SQ: state_next = ST_SC;
            ST_SC: state_next = ST_SI;
            ST_SI: state_next = ST_SO;
            ST_SO: state_next = ST_SR;
            ST_SR:
            begin
                if (which_reg)
                begin
                    job_next   = J_MX;
                    state_next = ST_DSTART;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_WALK:
            begin
                if (!(inmap_x_reg && inmap_y_reg) || n_out || n_wall
                    || (walk_cnt_reg == gdr_pkg::WALK_CNT_W'(gdr_pkg::WALK_STEPS - 1)))
                begin
                    state_next = ST_EX;
                end
            end
            ST_EX: state_next = ST_EY;
            ST_EY: state_next = ST_EF;
            ST_EF: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= J_ANG;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < gdr_pkg::MAP_SIZE; i++)
            begin
                wall_map_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            // write a map row in order with the rays
            if (q_pop && (q_item.mode == gdr_pkg::MODE_WRITE_ROW)
                && (32'(q_item.row_index) < 32'(gdr_pkg::MAP_SIZE)))
            begin
                wall_map_reg[IW'(q_item.row_index)] <= row_ext[gdr_pkg::MAP_SIZE-1:0];
            end
            // output register: load on finish, drop on take
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= gdr_pkg::MUL_P_W'(mul_a) * gdr_pkg::MUL_P_W'(mul_b);
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        case (state_reg)
            ST_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    case (job_reg)
                        J_ANG:
                        begin
                            ang_reg   <= ang_new;
                            t_reg     <= arg_x.t;
                            sneg_reg  <= arg_x.neg;
                            which_reg <= 1'b0;
                        end
                        J_MX:
                        begin
                            remx_reg    <= div_rsp.rem;
                            inmap_x_reg <= (div_rsp.quo < 32'(gdr_pkg::MAP_SIZE));
                            cx_reg      <= CW'(div_rsp.quo);
                        end
                        J_MY:
                        begin
                            remy_reg    <= div_rsp.rem;
                            inmap_y_reg <= (div_rsp.quo < 32'(gdr_pkg::MAP_SIZE));
                            cy_reg      <= CW'(div_rsp.quo);
                        end
                        J_DDX: ddx_reg <= DW'(div_rsp.quo);
                        J_SX:  sx_reg  <= DW'(div_rsp.quo);
                        J_DDY: ddy_reg <= DW'(div_rsp.quo);
                        J_SY:  sy_reg  <= DW'(div_rsp.quo);
                        default: ddx_reg <= ddx_reg;
                    endcase
                end
            end
            ST_SC:
            begin
                x2_reg <= prod_reg[29:14];
            end
            ST_SR:
            begin
                if (which_reg)
                begin
                    magy_reg <= prod_reg[29:14];
                    negy_reg <= sneg_reg && (prod_reg[29:14] != 16'd0);
                end
                else
                begin
                    magx_reg  <= prod_reg[29:14];
                    negx_reg  <= sneg_reg && (prod_reg[29:14] != 16'd0);
                    t_reg     <= arg_y.t;
                    sneg_reg  <= arg_y.neg;
                    which_reg <= 1'b1;
                end
                // clear walk state for the coming ray
                sx_reg       <= '0;
                sy_reg       <= '0;
                ddx_reg      <= '0;
                ddy_reg      <= '0;
                dist_reg     <= '0;
                side_reg     <= 1'b0;
                outmap_reg   <= 1'b1;
                walk_cnt_reg <= '0;
            end
            ST_WALK:
            begin
                if (inmap_x_reg && inmap_y_reg)
                begin
                    cx_reg       <= ncx;
                    cy_reg       <= ncy;
                    walk_cnt_reg <= walk_cnt_reg + 1'b1;
                    outmap_reg   <= !n_wall;
                    if (pick_y)
                    begin
                        dist_reg <= sy_reg;
                        sy_reg   <= sy_reg + ddy_reg;
                        side_reg <= 1'b1;
                    end
                    else
                    begin
                        dist_reg <= sx_reg;
                        sx_reg   <= sx_reg + ddx_reg;
                        side_reg <= 1'b0;
                    end
                end
            end
            ST_EY:
            begin
                hitx_reg <= end_coord(item_reg.origin_x, prod_reg[gdr_pkg::MUL_P_W-1:14],
                                      negx_reg);
            end
            ST_EF:
            begin
                hity_reg <= end_coord(item_reg.origin_y, prod_reg[gdr_pkg::MUL_P_W-1:14],
                                      negy_reg);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_reg.hit_x      <= hitx_reg;
                    out_reg.hit_y      <= hity_reg;
                    out_reg.distance   <= (dist_reg > DW'(gdr_pkg::MAX24))
                                          ? gdr_pkg::MAX24 : dist_reg[23:0];
                    out_reg.hit_side   <= side_reg;
                    out_reg.cell_x     <= outmap_reg ? 4'd0 : cx_reg[3:0];
                    out_reg.cell_y     <= outmap_reg ? 4'd0 : cy_reg[3:0];
                    out_reg.out_of_map <= outmap_reg;
                end
            end
            default:
            begin
                x2_reg <= x2_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (walk_cnt_reg < gdr_pkg::WALK_CNT_W'(gdr_pkg::WALK_STEPS)))
        else $error("grid walk ran past its step limit");
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DSTART) |-> !div_rsp.busy)
        else $error("divide issued while divider busy");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while a ray is in flight");

endmodule

// ===== sv/grid_dda_raycaster_core.sv =====
// ----------------------------------------------------------------------------
// grid_dda_raycaster_core: grid DDA ray caster, top level
// Map row writes give no result. A ray runs up to seven divides on the shared
// 1-bit/cycle divider, the sine polynomial on one multiplier and a grid walk
// of one grid cell per cycle, then forms the end point; rays are processed
// one at a time.
// Asynchronous active-low reset clears the map, the queue and the output.
// ----------------------------------------------------------------------------
module grid_dda_raycaster_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // row_index[3:0], row_bits[19:4], column[29:20],
                                   // origin_x[53:30], origin_y[77:54],
                                   // view_angle[89:78], zero fill
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // hit_x[23:0], hit_y[47:24], distance[71:48],
                                   // hit_side[72], cell_x[76:73], cell_y[80:77],
                                   // zero fill
    output logic        m_tuser,   // out_of_map
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    gdr_pkg::cfg_t     cfg_reg;
    gdr_pkg::item_t    q_item;
    logic              q_valid;
    logic              q_pop;
    gdr_pkg::div_req_t div_req;
    gdr_pkg::div_rsp_t div_rsp;
    gdr_pkg::result_t  result;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.field_of_view <= gdr_pkg::FOV_RESET;
            cfg_reg.screen_width  <= gdr_pkg::WIDTH_RESET;
            cfg_reg.cell_size     <= gdr_pkg::CELL_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                gdr_pkg::REG_FOV:   cfg_reg.field_of_view <= pwdata[11:0];
                gdr_pkg::REG_WIDTH: cfg_reg.screen_width  <= pwdata[10:0];
                gdr_pkg::REG_CELL:  cfg_reg.cell_size     <= pwdata[7:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            gdr_pkg::REG_FOV:   prdata = 32'(cfg_reg.field_of_view);
            gdr_pkg::REG_WIDTH: prdata = 32'(cfg_reg.screen_width);
            gdr_pkg::REG_CELL:  prdata = 32'(cfg_reg.cell_size);
            default:            prdata = 32'd0;
        endcase
    end

    gdr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    gdr_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    gdr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    // pack the result
    assign m_tdata = {7'd0, result.cell_y, result.cell_x, result.hit_side,
                      result.distance, result.hit_y, result.hit_x};
    assign m_tuser = result.out_of_map;

endmodule
